// ----- rtl/button_led_dimmer_controller_top_defines.svh -----
// assertion macros used by the dimmer controller rtl
`ifndef BUTTON_LED_DIMMER_CONTROLLER_TOP_DEFINES_SVH
`define BUTTON_LED_DIMMER_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BLDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BLDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bldc_pkg.sv -----
// types and constants of the button led dimmer controller
package bldc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IW  = 2;

    // step counter width of the remainder unit
    localparam int REM_CNT_W = $clog2(HUE_W);

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_HUE_TIMEOUT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FINE_STEP   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MAJOR_STEP  = 2'd2;

    localparam logic [CFG_W-1:0] RST_HUE_TIMEOUT = 16'd3000;
    localparam logic [CFG_W-1:0] RST_FINE_STEP   = 16'd320;
    localparam logic [CFG_W-1:0] RST_MAJOR_STEP  = 16'd10923;

    localparam logic [4:0]         BLINK_PERIOD = 5'd20;
    localparam logic [4:0]         BLINK_HALF   = BLINK_PERIOD / 5'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_STEP   = 8'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 8'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;

    // x / 5 == (x * RECIP5) >> 18 for any 14-bit x
    localparam logic [15:0] RECIP5 = 16'd52429;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_BRIGHT = 2'd2,
        MODE_HUE    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               ramp_up;
        logic [HUE_W-1:0]   hue_timer;
        logic [HUE_W-1:0]   display_hue;
        logic [LEVEL_W-1:0] display_level;
        logic [HUE_W-1:0]   saved_hue;
        logic [LEVEL_W-1:0] saved_level;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             start;
        logic [HUE_W-1:0] dividend;
        logic [HUE_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [HUE_W-1:0] rem;
    } t_rem_rsp;

endpackage

// ----- rtl/bldc_ram.sv -----
// generic single-port-write ram with registered read
module bldc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/bldc_rem.sv -----
// iterative remainder unit, one quotient bit per cycle
module bldc_rem
    import bldc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [HUE_W-1:0]     r_rem;
    logic [HUE_W-1:0]     r_dvd;
    logic [HUE_W-1:0]     r_div;

    logic [HUE_W:0]   w_sh;
    logic [HUE_W:0]   w_sub;
    logic             w_ge;

    assign w_sh  = {r_rem, r_dvd[HUE_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_div});
    assign w_sub = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[HUE_W-1:0] : w_sh[HUE_W-1:0];
                r_dvd <= {r_dvd[HUE_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == REM_CNT_W'(HUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/button_led_dimmer_controller_top.sv -----
// a result is registered after the input transaction passes the read, phase and update
// states, and the division state on a major hue advance (16-step remainder unit)
// one item at a time: the next input transaction is taken once the channel record has
// been written back and the result registered; output back-pressure can hold the update
// reset: synchronous active low; every channel reads as off with zero state
// (per-channel valid bits), configuration registers return to their default values
module button_led_dimmer_controller_top
    import bldc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_channel,
    input  logic               i_short_press,
    input  logic               i_long_hold,
    input  logic               i_double_press,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_led_channel,
    output logic [HUE_W-1:0]   o_shown_hue,
    output logic [LEVEL_W-1:0] o_shown_brightness,
    output logic               o_display_changed,
    output logic               o_save_request,
    output logic [1:0]         o_mode_now,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_wdata
);

`include "button_led_dimmer_controller_top_defines.svh"

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_PHASE = 5'b00100,
        S_DIV   = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_hue_timeout;
    logic [CFG_W-1:0]   r_fine_step;
    logic [CFG_W-1:0]   r_major_step;

    logic [2:0]         r_ch;
    logic [CH_AW-1:0]   r_addr;
    logic               r_oor;
    logic               r_sp;
    logic               r_lh;
    logic               r_dp;
    logic [CHANNELS-1:0] r_valid;

    t_entry             r_ent;
    logic [29:0]        r_prod;
    logic [4:0]         r_phase;

    logic               r_out_vld;
    logic [2:0]         r_out_ch;
    logic [HUE_W-1:0]   r_out_hue;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_disp;
    logic               r_out_save;
    logic [1:0]         r_out_mode;

    logic               w_in_acc;
    logic               w_in_oor;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_ent_rd;
    logic [11:0]        w_q;
    logic [HUE_W-1:0]   w_phase_full;
    logic               w_div_need;
    logic               w_out_free;
    logic               w_ram_we;
    t_rem_req           w_req;
    t_rem_rsp           w_rsp;

    t_entry             w_ent_new;
    logic               w_disp;
    logic               w_save;

    assign w_in_acc = i_valid && o_ready;
    assign w_in_oor = (7'(i_channel) >= 7'(CHANNELS));
    assign o_ready  = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_timeout <= RST_HUE_TIMEOUT;
            r_fine_step   <= RST_FINE_STEP;
            r_major_step  <= RST_MAJOR_STEP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HUE_TIMEOUT: r_hue_timeout <= i_cfg_wdata;
                CFG_FINE_STEP:   r_fine_step   <= i_cfg_wdata;
                CFG_MAJOR_STEP:  r_major_step  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bldc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (w_ent_new),
        .i_re    (w_in_acc),
        .i_raddr (CH_AW'(i_channel)),
        .o_rdata (w_rdata)
    );

    // a channel never written reads as its reset record
    assign w_ent_rd = (r_valid[r_addr] && !r_oor) ? t_entry'(w_rdata) : '0;

    // blink phase: hue_timer mod 20 via reciprocal of 5 on timer / 4
    assign w_q          = r_prod[29:18];
    assign w_phase_full = r_ent.hue_timer - (HUE_W'(w_q) << 4) - (HUE_W'(w_q) << 2);

    assign w_div_need = (r_ent.mode == MODE_HUE) && r_sp && !r_oor &&
                        (r_major_step != '0);

    assign w_req.start    = (r_state == S_PHASE) && w_div_need;
    assign w_req.dividend = r_ent.display_hue;
    assign w_req.divisor  = r_major_step;

    bldc_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_free = !r_out_vld || i_ready;
    assign w_ram_we   = (r_state == S_UPD) && w_out_free && !r_oor;

    // per-tick mode machine on the fetched channel record
    always_comb begin
        t_entry             e;
        t_mode              cur;
        t_mode              nxt;
        logic [LEVEL_W-1:0] lv;
        logic [HUE_W:0]     major_sum;
        logic [HUE_W-1:0]   major_hue;
        logic [HUE_W-1:0]   reload;

        e         = r_ent;
        cur       = r_ent.mode;
        nxt       = cur;
        w_disp    = 1'b0;
        w_save    = 1'b0;
        lv        = r_ent.display_level;
        major_sum = {1'b0, r_ent.display_hue} + {1'b0, r_major_step - w_rsp.rem};
        major_hue = (r_major_step == '0) ? r_ent.display_hue :
                    (major_sum[HUE_W] ? '0 : major_sum[HUE_W-1:0]);
        reload    = r_hue_timeout + HUE_W'(r_phase) - HUE_W'(1);

        unique case (cur)
            MODE_OFF: begin
                if (r_sp) nxt = MODE_ON;
            end
            MODE_ON: begin
                if (r_sp)      nxt = MODE_OFF;
                else if (r_lh) nxt = MODE_BRIGHT;
                else if (r_dp) nxt = MODE_HUE;
            end
            MODE_BRIGHT: begin
                if (r_lh) begin
                    if (e.ramp_up) begin
                        if (lv <= LEVEL_MAX - LEVEL_STEP) lv = lv + LEVEL_STEP;
                    end else begin
                        lv = (lv >= LEVEL_MIN + LEVEL_STEP) ? lv - LEVEL_STEP : LEVEL_MIN;
                    end
                    e.display_level = lv;
                    w_disp          = 1'b1;
                end else begin
                    nxt = MODE_ON;
                end
            end
            MODE_HUE: begin
                if (r_phase == 5'd0) begin
                    e.display_level = e.display_level >> 1;
                    w_disp          = 1'b1;
                end else if (r_phase == BLINK_HALF) begin
                    e.display_level = e.saved_level;
                    w_disp          = 1'b1;
                end
                if (r_sp) begin
                    e.display_hue = major_hue;
                    e.hue_timer   = reload;
                    w_disp        = 1'b1;
                end else if (r_lh) begin
                    e.display_hue = e.display_hue + r_fine_step;
                    e.hue_timer   = reload;
                    w_disp        = 1'b1;
                end else if ((e.hue_timer == '0) || r_dp) begin
                    nxt = MODE_ON;
                end else begin
                    e.hue_timer = e.hue_timer - HUE_W'(1);
                end
            end
            default: ;
        endcase

        if (nxt != cur) begin
            // exit action of the old mode
            if (cur == MODE_BRIGHT) begin
                e.saved_level = e.display_level;
                w_save        = 1'b1;
            end else if (cur == MODE_HUE) begin
                e.display_level = e.saved_level;
                e.saved_hue     = e.display_hue;
                w_save          = 1'b1;
            end
            // entry action of the new mode
            unique case (nxt)
                MODE_OFF: begin
                    e.display_hue   = '0;
                    e.display_level = '0;
                    w_disp          = 1'b1;
                end
                MODE_ON: begin
                    e.display_hue   = e.saved_hue;
                    e.display_level = e.saved_level;
                    w_disp          = 1'b1;
                end
                MODE_BRIGHT: e.ramp_up   = !e.ramp_up;
                MODE_HUE:    e.hue_timer = r_hue_timeout;
                default: ;
            endcase
            e.mode = nxt;
        end

        w_ent_new = e;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_READ;
            S_READ:  n_state = S_PHASE;
            S_PHASE: n_state = w_div_need ? S_DIV : S_UPD;
            S_DIV:   if (w_rsp.done) n_state = S_UPD;
            S_UPD:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if ((r_state == S_UPD) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch   <= i_channel;
            r_addr <= CH_AW'(i_channel);
            r_oor  <= w_in_oor;
            r_sp   <= i_short_press;
            r_lh   <= i_long_hold;
            r_dp   <= i_double_press;
        end
        if (r_state == S_READ) begin
            r_ent  <= w_ent_rd;
            r_prod <= 30'(w_ent_rd.hue_timer[HUE_W-1:2]) * 30'(RECIP5);
        end
        if (r_state == S_PHASE) begin
            r_phase <= w_phase_full[4:0];
        end
        if ((r_state == S_UPD) && w_out_free) begin
            r_out_ch    <= r_ch;
            r_out_hue   <= r_oor ? '0 : w_ent_new.display_hue;
            r_out_level <= r_oor ? '0 : w_ent_new.display_level;
            r_out_disp  <= !r_oor && w_disp;
            r_out_save  <= !r_oor && w_save;
            r_out_mode  <= r_oor ? 2'd0 : w_ent_new.mode;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_led_channel      = r_out_ch;
    assign o_shown_hue        = r_out_hue;
    assign o_shown_brightness = r_out_level;
    assign o_display_changed  = r_out_disp;
    assign o_save_request     = r_out_save;
    assign o_mode_now         = r_out_mode;

    `BLDC_ASSERT_NEXT(a_one_item, w_in_acc, !o_ready, "input taken while an item is in flight")
    `BLDC_ASSERT_NOW(a_wr_in_upd, w_ram_we, (r_state == S_UPD) && !r_oor, "state write outside update")
    `BLDC_ASSERT_NOW(a_out_from_upd, $rose(o_valid), $past(r_state == S_UPD), "result not from update")
    `BLDC_ASSERT_NOW(a_div_step, w_req.start, r_major_step != '0, "remainder started with zero step")

endmodule

// ----- sim/tb_button_led_dimmer_controller_top.sv -----
// self-checking testbench for the button led dimmer controller
`timescale 1ns / 100ps

module tb_button_led_dimmer_controller_top;
    import bldc_pkg::*;

    localparam int RAND_TICKS    = 750;
    localparam int SETTING_COUNT = 6;
    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_OFF      = 300;

    // index past the register list, writes to it are dropped
    localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0] chan;
        logic       sp;
        logic       lh;
        logic       dp;
    } t_tick;

    typedef struct packed {
        logic [2:0]         chan;
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] level;
        logic               changed;
        logic               save;
        t_mode              mode;
    } t_led_state;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [2:0]         i_channel      = '0;
    logic               i_short_press  = 1'b0;
    logic               i_long_hold    = 1'b0;
    logic               i_double_press = 1'b0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [2:0]         o_led_channel;
    logic [HUE_W-1:0]   o_shown_hue;
    logic [LEVEL_W-1:0] o_shown_brightness;
    logic               o_display_changed;
    logic               o_save_request;
    logic [1:0]         o_mode_now;
    logic               i_cfg_wr_en    = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_index    = '0;
    logic [CFG_W-1:0]   i_cfg_wdata    = '0;

    // per-channel copy of the controller state
    t_mode              ch_mode        [CHANNELS];
    bit                 ch_ramp_up     [CHANNELS];
    bit [HUE_W-1:0]     ch_timer       [CHANNELS];
    bit [HUE_W-1:0]     ch_hue         [CHANNELS];
    bit [LEVEL_W-1:0]   ch_level       [CHANNELS];
    bit [HUE_W-1:0]     ch_saved_hue   [CHANNELS];
    bit [LEVEL_W-1:0]   ch_saved_level [CHANNELS];
    bit [CFG_W-1:0]     cfg_timeout;
    bit [CFG_W-1:0]     cfg_fine;
    bit [CFG_W-1:0]     cfg_major;

    t_tick      pending_ticks[$];
    t_led_state expected_leds[$];

    int  ticks_queued  = 0;
    int  ticks_taken   = 0;
    int  leds_checked  = 0;
    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  major_steps   = 0;
    int  hue_timeouts  = 0;
    int  hold_offs     = 0;
    int  next_hold_at  = 60;
    int  send_gap      = 0;
    int  recv_stall    = 0;
    bit  send_calm     = 1'b0;
    bit  recv_calm     = 1'b0;
    bit  tick_taken    = 1'b0;
    bit  led_taken     = 1'b0;

    button_led_dimmer_controller_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_channel         (i_channel),
        .i_short_press     (i_short_press),
        .i_long_hold       (i_long_hold),
        .i_double_press    (i_double_press),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_led_channel     (o_led_channel),
        .o_shown_hue       (o_shown_hue),
        .o_shown_brightness(o_shown_brightness),
        .o_display_changed (o_display_changed),
        .o_save_request    (o_save_request),
        .o_mode_now        (o_mode_now),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    // smallest multiple of the major step strictly above the hue, zero past the top
    function automatic logic [HUE_W-1:0] next_major_hue(logic [HUE_W-1:0] hue);
        logic [31:0] up;
        if (cfg_major == '0) begin
            return hue;
        end
        up = (32'(hue) / 32'(cfg_major) + 32'd1) * 32'(cfg_major);
        return (up > 32'h0000_ffff) ? '0 : up[HUE_W-1:0];
    endfunction

    // advances one channel by one button tick and returns what it shows
    function automatic t_led_state step_channel(t_tick t);
        int unsigned c;
        int unsigned lv;
        int unsigned phase;
        t_mode       cur;
        t_mode       nxt;
        bit          shown;
        bit          saved;
        t_led_state  r;
        c     = 32'(t.chan);
        cur   = ch_mode[c];
        nxt   = cur;
        shown = 1'b0;
        saved = 1'b0;
        case (cur)
            MODE_OFF: begin
                if (t.sp) nxt = MODE_ON;
            end
            MODE_ON: begin
                if (t.sp)      nxt = MODE_OFF;
                else if (t.lh) nxt = MODE_BRIGHT;
                else if (t.dp) nxt = MODE_HUE;
            end
            MODE_BRIGHT: begin
                if (t.lh) begin
                    lv = 32'(ch_level[c]);
                    if (ch_ramp_up[c]) begin
                        if (lv <= 32'(LEVEL_MAX) - 32'(LEVEL_STEP)) lv += 32'(LEVEL_STEP);
                    end else begin
                        if (lv >= 32'(LEVEL_STEP)) lv -= 32'(LEVEL_STEP);
                        if (lv < 32'(LEVEL_MIN)) lv = 32'(LEVEL_MIN);
                    end
                    ch_level[c] = lv[LEVEL_W-1:0];
                    shown = 1'b1;
                end else begin
                    nxt = MODE_ON;
                end
            end
            default: begin
                // blink runs off the timer before the buttons are looked at
                phase = 32'(ch_timer[c] % 16'(BLINK_PERIOD));
                if (phase == 0) begin
                    ch_level[c] = ch_level[c] >> 1;
                    shown = 1'b1;
                end else if (phase == 32'(BLINK_HALF)) begin
                    ch_level[c] = ch_saved_level[c];
                    shown = 1'b1;
                end
                if (t.sp) begin
                    ch_hue[c]   = next_major_hue(ch_hue[c]);
                    ch_timer[c] = cfg_timeout + HUE_W'(phase) - 16'd1;
                    shown = 1'b1;
                    major_steps++;
                end else if (t.lh) begin
                    ch_hue[c]   = ch_hue[c] + cfg_fine;
                    ch_timer[c] = cfg_timeout + HUE_W'(phase) - 16'd1;
                    shown = 1'b1;
                end else if (ch_timer[c] == '0 || t.dp) begin
                    if (!t.dp) hue_timeouts++;
                    nxt = MODE_ON;
                end else begin
                    ch_timer[c] = ch_timer[c] - 16'd1;
                end
            end
        endcase

        if (nxt != cur) begin
            if (cur == MODE_BRIGHT) begin
                ch_saved_level[c] = ch_level[c];
                saved = 1'b1;
            end else if (cur == MODE_HUE) begin
                ch_level[c]     = ch_saved_level[c];
                ch_saved_hue[c] = ch_hue[c];
                saved = 1'b1;
            end
            case (nxt)
                MODE_OFF: begin
                    ch_hue[c]   = '0;
                    ch_level[c] = '0;
                    shown = 1'b1;
                end
                MODE_ON: begin
                    ch_hue[c]   = ch_saved_hue[c];
                    ch_level[c] = ch_saved_level[c];
                    shown = 1'b1;
                end
                MODE_BRIGHT: ch_ramp_up[c] = !ch_ramp_up[c];
                default:     ch_timer[c] = cfg_timeout;
            endcase
            ch_mode[c] = nxt;
        end

        r.chan    = t.chan;
        r.hue     = ch_hue[c];
        r.level   = ch_level[c];
        r.changed = shown;
        r.save    = saved;
        r.mode    = ch_mode[c];
        return r;
    endfunction

    task automatic offer_tick(input int unsigned c, input bit sp, input bit lh, input bit dp);
        t_tick t;
        t.chan = c[2:0];
        t.sp   = sp;
        t.lh   = lh;
        t.dp   = dp;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || expected_leds.size() != 0) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] fine,
                                  input logic [CFG_W-1:0] major, input bit poke_spare);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_HUE_TIMEOUT;
        i_cfg_wdata <= timeout;
        cfg_timeout = timeout;
        @(negedge i_clk);
        i_cfg_index <= CFG_FINE_STEP;
        i_cfg_wdata <= fine;
        cfg_fine = fine;
        @(negedge i_clk);
        i_cfg_index <= CFG_MAJOR_STEP;
        i_cfg_wdata <= major;
        cfg_major = major;
        @(negedge i_clk);
        if (poke_spare) begin
            i_cfg_index <= CFG_SPARE;
            i_cfg_wdata <= '1;
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // picks a button gesture that makes sense for the channel's current mode, now and then random ticks
    task automatic run_gesture();
        int unsigned c;
        int unsigned len;
        int unsigned roll;
        t_mode       m;
        while (ticks_taken != ticks_queued) @(negedge i_clk);
        c    = $urandom_range(0, CHANNELS - 1);
        m    = ch_mode[c];
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            repeat ($urandom_range(1, 4))
                offer_tick($urandom_range(0, CHANNELS - 1), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (m == MODE_OFF || (m == MODE_ON && roll < 3)) begin
            offer_tick(c, 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (m == MODE_BRIGHT || (m == MODE_ON && roll < 6)) begin
            // mostly short ramps, now and then one long enough to hit the clamp
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 140)
                                              : $urandom_range(1, 20);
            repeat (len) offer_tick(c, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
            offer_tick(c, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        end else begin
            if (m == MODE_ON) offer_tick(c, 1'b0, 1'b0, 1'b1);
            len = $urandom_range(3, 40);
            repeat (len) begin
                roll = $urandom_range(0, 19);
                if (roll < 3)
                    offer_tick(c, 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else if (roll < 8)
                    offer_tick(c, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
                else
                    offer_tick(c, 1'b0, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 2) != 0) offer_tick(c, 1'b0, 1'b0, 1'b1);
        end
    endtask

    // input side: prediction happens when the transaction is taken
    always @(posedge i_clk) begin : take_ticks
        t_tick t;
        tick_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            t.chan = i_channel;
            t.sp   = i_short_press;
            t.lh   = i_long_hold;
            t.dp   = i_double_press;
            expected_leds.push_back(step_channel(t));
            ticks_taken++;
        end
    end

    always @(negedge i_clk) begin : drive_ticks
        t_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            if (i_valid) begin
                if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                send_gap = draw_wait(send_calm);
            end
            if (send_gap > 0 || pending_ticks.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_valid <= 1'b0;
            end else begin
                t = pending_ticks.pop_front();
                i_valid        <= 1'b1;
                i_channel      <= t.chan;
                i_short_press  <= t.sp;
                i_long_hold    <= t.lh;
                i_double_press <= t.dp;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (led_taken) begin
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_stall = draw_wait(recv_calm);
            end
            // long hold-off while plenty is queued so the block backs up
            if (leds_checked >= next_hold_at && pending_ticks.size() >= 12) begin
                recv_stall   = HOLD_OFF;
                next_hold_at = leds_checked + 200;
                hold_offs++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_leds
        t_led_state got;
        t_led_state want;
        led_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            got.chan    = o_led_channel;
            got.hue     = o_shown_hue;
            got.level   = o_shown_brightness;
            got.changed = o_display_changed;
            got.save    = o_save_request;
            got.mode    = t_mode'(o_mode_now);
            leds_checked++;
            if (expected_leds.size() == 0) begin
                fail_count++;
                $display("%0t: mismatch expected none, actual ch %0d hue %0d lvl %0d",
                         $time, got.chan, got.hue, got.level);
            end else begin
                want = expected_leds.pop_front();
                if (got !== want) begin
                    fail_count++;
                    $display({"%0t: mismatch expected ch %0d hue %0d lvl %0d chg %0b ",
                              "save %0b mode %0d, actual ch %0d hue %0d lvl %0d chg %0b ",
                              "save %0b mode %0d"},
                             $time, want.chan, want.hue, want.level, want.changed,
                             want.save, want.mode, got.chan, got.hue, got.level,
                             got.changed, got.save, got.mode);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: run stuck, %0d transactions still expected",
                     $time, expected_leds.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : run_test
        int phase_start;
        for (int c = 0; c < CHANNELS; c++) begin
            ch_mode[c]        = MODE_OFF;
            ch_ramp_up[c]     = 1'b0;
            ch_timer[c]       = '0;
            ch_hue[c]         = '0;
            ch_level[c]       = '0;
            ch_saved_hue[c]   = '0;
            ch_saved_level[c] = '0;
        end
        cfg_timeout = RST_HUE_TIMEOUT;
        cfg_fine    = RST_FINE_STEP;
        cfg_major   = RST_MAJOR_STEP;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through every mode change under the reset settings
        offer_tick(0, 1'b0, 1'b0, 1'b0);
        offer_tick(0, 1'b0, 1'b1, 1'b1);
        offer_tick(0, 1'b1, 1'b0, 1'b0);
        offer_tick(0, 1'b0, 1'b1, 1'b0);
        repeat (3) offer_tick(0, 1'b0, 1'b1, 1'b0);
        offer_tick(0, 1'b0, 1'b0, 1'b0);
        offer_tick(0, 1'b0, 1'b1, 1'b0);
        repeat (3) offer_tick(0, 1'b0, 1'b1, 1'b0);
        offer_tick(0, 1'b0, 1'b0, 1'b0);
        offer_tick(0, 1'b0, 1'b0, 1'b1);
        offer_tick(0, 1'b0, 1'b0, 1'b0);
        offer_tick(0, 1'b1, 1'b0, 1'b0);
        offer_tick(0, 1'b0, 1'b1, 1'b0);
        offer_tick(0, 1'b1, 1'b1, 1'b1);
        offer_tick(0, 1'b0, 1'b0, 1'b1);
        offer_tick(0, 1'b1, 1'b0, 1'b1);
        offer_tick(7, 1'b1, 1'b0, 1'b0);
        offer_tick(7, 1'b1, 1'b1, 1'b1);
        offer_tick(5, 1'b1, 1'b0, 1'b0);
        offer_tick(5, 1'b0, 1'b1, 1'b1);
        offer_tick(5, 1'b0, 1'b0, 1'b1);

        for (int p = 0; p < SETTING_COUNT; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: apply_settings(16'd25, 16'hffff, 16'd1, 1'b0);
                    2: apply_settings(16'd1, 16'd0, 16'hffff, 1'b0);
                    3: apply_settings(16'hffff, 16'd1, 16'd0, 1'b1);
                    4: apply_settings(16'd7, 16'($urandom_range(0, 65535)),
                                      16'($urandom_range(1, 65535)), 1'b0);
                    default: apply_settings(16'd65000, 16'($urandom_range(0, 65535)),
                                            16'($urandom_range(1, 40)), 1'b0);
                endcase
            end
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < RAND_TICKS / SETTING_COUNT) run_gesture();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("checked %0d led transactions over %0d register settings, %0d long hold-offs",
                 leds_checked, SETTING_COUNT, hold_offs);
        $display("major hue advances %0d, hue mode timeouts %0d, mismatches %0d",
                 major_steps, hue_timeouts, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
